/* design/obm_pkg.sv */
// shared types and constants for the order book matcher
package obm_pkg;

	localparam int unsigned BOOK_DEPTH_DEF = 32;
	localparam int unsigned PRICE_W        = 48;
	localparam int unsigned AMT_W          = 48;
	localparam int unsigned PRODUCT_W      = 8;
	localparam int unsigned SLOT_W         = 16;
	localparam int unsigned TAG_W          = 26;
	localparam int unsigned KEY_W          = 24;
	localparam int unsigned KEY_LSB        = 2;
	localparam int unsigned TAG_SIDE       = 1;
	localparam int unsigned TAG_USER       = 0;
	localparam int unsigned MAX_RESULTS    = 32;
	localparam int unsigned RES_CNT_W      = 6;

	// request codes
	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_MATCH  = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// one book entry: tag is {product, time slot, side, user}
	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [AMT_W-1:0]   amount;
		logic [TAG_W-1:0]   tag;
	} entry_t;

	// one sale handed to the result stage
	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [AMT_W-1:0]   amount;
		logic               kind;
		logic               user;
	} sale_t;

	// control from the sequencer to the result stage
	typedef struct packed {
		logic push;
		logic fin;
	} out_ctl_t;

endpackage

/* design/order_book_matcher_top.sv */
// order book matcher: sequencer around the book and scratch memories
//
// channel   direction  handshake                  payload
// request   in         start & !busy              kind product time_slot side price amount by_user
// result    out        res_valid, one cycle each  sale_price sale_amount sale_kind user_sale
//                                                 empty_res last
//
// insert writes the book entry from idle; remove scans the book and compacts it
// match: a ranking pass over the book for each order of the product and slot, then
// a walk over the asks, each stepping through the bids; all paced by the single
// read port of the book memory
// after reset the book is empty and no clearing pass runs
// results leave one cycle each and the receiver cannot stall them
module order_book_matcher_top #(
	parameter int unsigned BOOK_DEPTH = obm_pkg::BOOK_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      kind,
	input  logic [obm_pkg::PRODUCT_W-1:0]   product,
	input  logic [obm_pkg::SLOT_W-1:0]      time_slot,
	input  logic                            side,
	input  logic [obm_pkg::PRICE_W-1:0]     price,
	input  logic [obm_pkg::AMT_W-1:0]       amount,
	input  logic                            by_user,
	output logic                            res_valid,
	output logic [obm_pkg::PRICE_W-1:0]     sale_price,
	output logic [obm_pkg::AMT_W-1:0]       sale_amount,
	output logic                            sale_kind,
	output logic                            user_sale,
	output logic                            empty_res,
	output logic                            last
);
	import obm_pkg::*;

	localparam int unsigned IW = $clog2(BOOK_DEPTH);
	localparam int unsigned CW = $clog2(BOOK_DEPTH + 1);

	typedef enum logic [12:0] {
		ST_IDLE    = 13'b0000000000001,
		ST_RM      = 13'b0000000000010,
		ST_RK_LD   = 13'b0000000000100,
		ST_RK_CAP  = 13'b0000000001000,
		ST_RK_SCAN = 13'b0000000010000,
		ST_MA_CHK  = 13'b0000000100000,
		ST_MA_OR   = 13'b0000001000000,
		ST_MA_BK   = 13'b0000010000000,
		ST_MA_CAP  = 13'b0000100000000,
		ST_MB_OR   = 13'b0001000000000,
		ST_MB_BK   = 13'b0010000000000,
		ST_MB_EV   = 13'b0100000000000,
		ST_FIN     = 13'b1000000000000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      i_q;
	logic [CW-1:0]      k_q;
	logic [IW-1:0]      kr_q;
	logic               pend_q;
	logic [IW-1:0]      rank_q;
	logic [CW-1:0]      w_q;
	logic [KEY_W-1:0]   key_q;
	entry_t             ent_q;
	logic [CW-1:0]      na_q;
	logic [CW-1:0]      nb_q;
	logic [CW-1:0]      a_q;
	logic [CW-1:0]      b_q;
	logic [PRICE_W-1:0] ap_q;
	logic               au_q;
	logic [AMT_W-1:0]   wa_q;
	logic [IW-1:0]      bi_q;

	kind_t              kind_c;
	logic [IW-1:0]      bk_rd_addr;
	entry_t             bk_rd;
	logic               bk_wr_en;
	logic [IW-1:0]      bk_wr_addr;
	entry_t             bk_wr_data;
	logic [IW:0]        ord_rd_addr;
	logic [IW-1:0]      ord_rd_data;
	logic               ord_wr_en;
	logic [IW:0]        ord_wr_addr;
	logic               wk_wr_en;
	logic [IW-1:0]      wk_rd_addr;
	logic [AMT_W-1:0]   wk_rd_data;
	logic [IW-1:0]      wk_wr_addr;
	logic [AMT_W-1:0]   wk_wr_data;
	out_ctl_t           octl;
	sale_t              sale;
	logic               rk_hit;
	logic               rk_done;
	logic               bid_low;
	logic               bid_cover;
	logic               bid_nz;

	assign kind_c = kind_t'(kind);
	assign busy   = (state_q != ST_IDLE);

	// ranking compare: same product, slot and side, ahead in price or insertion order
	always_comb begin
		rk_hit = 1'b0;
		if (pend_q && (bk_rd.tag[TAG_W-1:KEY_LSB] == key_q) &&
		    (bk_rd.tag[TAG_SIDE] == ent_q.tag[TAG_SIDE])) begin
			if (bk_rd.price == ent_q.price) begin
				rk_hit = (kr_q < i_q[IW-1:0]);
			end else if (ent_q.tag[TAG_SIDE]) begin
				rk_hit = (bk_rd.price > ent_q.price);
			end else begin
				rk_hit = (bk_rd.price < ent_q.price);
			end
		end
	end

	assign rk_done   = (k_q == count_q) && !pend_q;
	assign bid_low   = (bk_rd.price < ap_q);
	assign bid_cover = (wk_rd_data >= wa_q);
	assign bid_nz    = (wk_rd_data != '0);

	// memory accesses and result pushes
	always_comb begin
		bk_rd_addr  = '0;
		bk_wr_en    = 1'b0;
		bk_wr_addr  = count_q[IW-1:0];
		bk_wr_data  = '{price: price, amount: amount,
			tag: {product, time_slot, side, by_user}};
		ord_rd_addr = '0;
		ord_wr_en   = 1'b0;
		ord_wr_addr = {ent_q.tag[TAG_SIDE], rank_q};
		wk_rd_addr  = '0;
		wk_wr_en    = 1'b0;
		wk_wr_addr  = i_q[IW-1:0];
		wk_wr_data  = ent_q.amount;
		octl        = '0;
		sale        = '{price: ap_q, amount: wa_q,
			kind: bk_rd.tag[TAG_USER] & ~au_q, user: bk_rd.tag[TAG_USER] | au_q};
		unique case (state_q)
			ST_IDLE: begin
				if (start && (kind_c == KIND_INSERT) && (count_q < CW'(BOOK_DEPTH))) begin
					bk_wr_en = 1'b1;
				end
			end
			ST_RM: begin
				if (i_q < count_q) begin
					bk_rd_addr = i_q[IW-1:0];
				end
				// compaction writes trail the read pointer
				if (pend_q && !bk_rd.tag[TAG_USER]) begin
					bk_wr_en   = 1'b1;
					bk_wr_addr = w_q[IW-1:0];
					bk_wr_data = bk_rd;
				end
			end
			ST_RK_LD: begin
				bk_rd_addr = i_q[IW-1:0];
			end
			ST_RK_SCAN: begin
				if (k_q < count_q) begin
					bk_rd_addr = k_q[IW-1:0];
				end
				if (rk_done) begin
					ord_wr_en = 1'b1;
					wk_wr_en  = 1'b1;
				end
			end
			ST_MA_OR: begin
				ord_rd_addr = {1'b0, a_q[IW-1:0]};
			end
			ST_MA_BK: begin
				bk_rd_addr = ord_rd_data;
			end
			ST_MB_OR: begin
				ord_rd_addr = {1'b1, b_q[IW-1:0]};
			end
			ST_MB_BK: begin
				bk_rd_addr = ord_rd_data;
				wk_rd_addr = ord_rd_data;
			end
			ST_MB_EV: begin
				wk_wr_addr = bi_q;
				if (!bid_low) begin
					if (bid_cover) begin
						octl.push  = 1'b1;
						wk_wr_en   = 1'b1;
						wk_wr_data = wk_rd_data - wa_q;
					end else if (bid_nz) begin
						octl.push   = 1'b1;
						sale.amount = wk_rd_data;
						wk_wr_en    = 1'b1;
						wk_wr_data  = '0;
					end
				end
			end
			ST_FIN: begin
				octl.fin = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			i_q     <= '0;
			k_q     <= '0;
			kr_q    <= '0;
			pend_q  <= 1'b0;
			rank_q  <= '0;
			w_q     <= '0;
			key_q   <= '0;
			ent_q   <= '0;
			na_q    <= '0;
			nb_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			ap_q    <= '0;
			au_q    <= 1'b0;
			wa_q    <= '0;
			bi_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unique case (kind_c)
							KIND_INSERT: begin
								if (count_q < CW'(BOOK_DEPTH)) begin
									count_q <= count_q + CW'(1);
								end
							end
							KIND_MATCH: begin
								key_q   <= {product, time_slot};
								i_q     <= '0;
								na_q    <= '0;
								nb_q    <= '0;
								state_q <= ST_RK_LD;
							end
							KIND_REMOVE: begin
								i_q     <= '0;
								w_q     <= '0;
								pend_q  <= 1'b0;
								state_q <= ST_RM;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RM: begin
					if (i_q < count_q) begin
						i_q    <= i_q + CW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && !bk_rd.tag[TAG_USER]) begin
						w_q <= w_q + CW'(1);
					end
					if ((i_q == count_q) && !pend_q) begin
						count_q <= w_q;
						state_q <= ST_IDLE;
					end
				end
				ST_RK_LD: begin
					if (i_q < count_q) begin
						state_q <= ST_RK_CAP;
					end else begin
						state_q <= ST_MA_CHK;
					end
				end
				ST_RK_CAP: begin
					ent_q <= bk_rd;
					if (bk_rd.tag[TAG_W-1:KEY_LSB] == key_q) begin
						k_q     <= '0;
						pend_q  <= 1'b0;
						rank_q  <= '0;
						state_q <= ST_RK_SCAN;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= ST_RK_LD;
					end
				end
				ST_RK_SCAN: begin
					if (k_q < count_q) begin
						k_q    <= k_q + CW'(1);
						kr_q   <= k_q[IW-1:0];
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (rk_hit) begin
						rank_q <= rank_q + IW'(1);
					end
					if (rk_done) begin
						if (ent_q.tag[TAG_SIDE]) begin
							nb_q <= nb_q + CW'(1);
						end else begin
							na_q <= na_q + CW'(1);
						end
						i_q     <= i_q + CW'(1);
						state_q <= ST_RK_LD;
					end
				end
				ST_MA_CHK: begin
					a_q <= '0;
					if ((na_q == '0) || (nb_q == '0)) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_MA_OR;
					end
				end
				ST_MA_OR: begin
					state_q <= ST_MA_BK;
				end
				ST_MA_BK: begin
					state_q <= ST_MA_CAP;
				end
				ST_MA_CAP: begin
					ap_q    <= bk_rd.price;
					au_q    <= bk_rd.tag[TAG_USER];
					wa_q    <= bk_rd.amount;
					b_q     <= '0;
					state_q <= ST_MB_OR;
				end
				ST_MB_OR: begin
					state_q <= ST_MB_BK;
				end
				ST_MB_BK: begin
					bi_q    <= ord_rd_data;
					state_q <= ST_MB_EV;
				end
				ST_MB_EV: begin
					// a covering bid ends this ask, otherwise move to the next bid, or to the next ask once the bids run out
					if (!bid_low && bid_cover) begin
						if ((a_q + CW'(1)) < na_q) begin
							a_q     <= a_q + CW'(1);
							state_q <= ST_MA_OR;
						end else begin
							state_q <= ST_FIN;
						end
					end else begin
						if (!bid_low && bid_nz) begin
							wa_q <= wa_q - wk_rd_data;
						end
						if ((b_q + CW'(1)) < nb_q) begin
							b_q     <= b_q + CW'(1);
							state_q <= ST_MB_OR;
						end else if ((a_q + CW'(1)) < na_q) begin
							a_q     <= a_q + CW'(1);
							state_q <= ST_MA_OR;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	obm_book #(
		.BOOK_DEPTH(BOOK_DEPTH)
	) u_book (
		.clk    (clk),
		.rd_addr(bk_rd_addr),
		.rd_data(bk_rd),
		.wr_en  (bk_wr_en),
		.wr_addr(bk_wr_addr),
		.wr_data(bk_wr_data)
	);

	obm_scratch #(
		.BOOK_DEPTH(BOOK_DEPTH)
	) u_scratch (
		.clk        (clk),
		.ord_rd_addr(ord_rd_addr),
		.ord_rd_data(ord_rd_data),
		.ord_wr_en  (ord_wr_en),
		.ord_wr_addr(ord_wr_addr),
		.ord_wr_data(i_q[IW-1:0]),
		.wk_rd_addr (wk_rd_addr),
		.wk_rd_data (wk_rd_data),
		.wk_wr_en   (wk_wr_en),
		.wk_wr_addr (wk_wr_addr),
		.wk_wr_data (wk_wr_data)
	);

	obm_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (octl),
		.sale       (sale),
		.res_valid  (res_valid),
		.sale_price (sale_price),
		.sale_amount(sale_amount),
		.sale_kind  (sale_kind),
		.user_sale  (user_sale),
		.empty_res  (empty_res),
		.last       (last)
	);

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(BOOK_DEPTH))
		else $error("book count beyond depth");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without a start");
	a_side_split: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MA_CHK) |->
		(({1'b0, na_q} + {1'b0, nb_q}) <= {1'b0, count_q}))
		else $error("more ranked orders than book entries");
`endif

endmodule

/* design/obm_book.sv */
// book memory: one write port, one registered read port
module obm_book #(
	parameter int unsigned BOOK_DEPTH = obm_pkg::BOOK_DEPTH_DEF,
	localparam int unsigned IW = $clog2(BOOK_DEPTH)
) (
	input  logic            clk,
	input  logic [IW-1:0]   rd_addr,
	output obm_pkg::entry_t rd_data,
	input  logic            wr_en,
	input  logic [IW-1:0]   wr_addr,
	input  obm_pkg::entry_t wr_data
);
	import obm_pkg::*;

	entry_t mem_q [BOOK_DEPTH];
	entry_t rd_data_q;

	// write and read, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* design/obm_scratch.sv */
// match scratch memories: sorted ask and bid lists, working amounts
module obm_scratch #(
	parameter int unsigned BOOK_DEPTH = obm_pkg::BOOK_DEPTH_DEF,
	localparam int unsigned IW = $clog2(BOOK_DEPTH)
) (
	input  logic                        clk,
	input  logic [IW:0]                 ord_rd_addr,
	output logic [IW-1:0]               ord_rd_data,
	input  logic                        ord_wr_en,
	input  logic [IW:0]                 ord_wr_addr,
	input  logic [IW-1:0]               ord_wr_data,
	input  logic [IW-1:0]               wk_rd_addr,
	output logic [obm_pkg::AMT_W-1:0]   wk_rd_data,
	input  logic                        wk_wr_en,
	input  logic [IW-1:0]               wk_wr_addr,
	input  logic [obm_pkg::AMT_W-1:0]   wk_wr_data
);
	import obm_pkg::*;

	localparam int unsigned ORD_DEPTH = 2 * (1 << IW);

	logic [IW-1:0]    ord_q [ORD_DEPTH];
	logic [AMT_W-1:0] wk_q [BOOK_DEPTH];
	logic [IW-1:0]    ord_rd_q;
	logic [AMT_W-1:0] wk_rd_q;

	// order lists, upper half holds bids
	always_ff @(posedge clk) begin
		if (ord_wr_en) begin
			ord_q[ord_wr_addr] <= ord_wr_data;
		end
		ord_rd_q <= ord_q[ord_rd_addr];
	end

	// working amounts
	always_ff @(posedge clk) begin
		if (wk_wr_en) begin
			wk_q[wk_wr_addr] <= wk_wr_data;
		end
		wk_rd_q <= wk_q[wk_rd_addr];
	end

	assign ord_rd_data = ord_rd_q;
	assign wk_rd_data  = wk_rd_q;

endmodule

/* design/obm_out.sv */
// result stage: holds one sale back so the final one carries last
module obm_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  obm_pkg::out_ctl_t             ctl,
	input  obm_pkg::sale_t                sale,
	output logic                          res_valid,
	output logic [obm_pkg::PRICE_W-1:0]   sale_price,
	output logic [obm_pkg::AMT_W-1:0]     sale_amount,
	output logic                          sale_kind,
	output logic                          user_sale,
	output logic                          empty_res,
	output logic                          last
);
	import obm_pkg::*;

	logic                 res_valid_q;
	logic                 pend_vld_q;
	sale_t                pend_q;
	logic [RES_CNT_W-1:0] n_q;
	sale_t                res_q;
	logic                 empty_q;
	logic                 last_q;
	logic                 take;

	assign take = ctl.push && (n_q < RES_CNT_W'(MAX_RESULTS));

	// control: strobe, held sale and result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			pend_vld_q  <= 1'b0;
			n_q         <= '0;
		end else begin
			res_valid_q <= 1'b0;
			if (ctl.fin) begin
				res_valid_q <= 1'b1;
				pend_vld_q  <= 1'b0;
				n_q         <= '0;
			end else if (take) begin
				res_valid_q <= pend_vld_q;
				pend_vld_q  <= 1'b1;
				n_q         <= n_q + RES_CNT_W'(1);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			last_q <= 1'b1;
			if (pend_vld_q) begin
				res_q   <= pend_q;
				empty_q <= 1'b0;
			end else begin
				res_q   <= '0;
				empty_q <= 1'b1;
			end
		end else if (take) begin
			res_q   <= pend_q;
			empty_q <= 1'b0;
			last_q  <= 1'b0;
			pend_q  <= sale;
		end
	end

	assign res_valid   = res_valid_q;
	assign sale_price  = res_q.price;
	assign sale_amount = res_q.amount;
	assign sale_kind   = res_q.kind;
	assign user_sale   = res_q.user;
	assign empty_res   = empty_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	a_fin_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |=> res_valid)
		else $error("finish did not produce a final result");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && empty_res) |-> last)
		else $error("empty marker without last");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= RES_CNT_W'(MAX_RESULTS))
		else $error("result count beyond cap");
`endif

endmodule
